### sv/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg: shared types and constants of the stick polar converter
// Holds the per-stick working record, the queued item record and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int XW        = 34;   // working width of x and y
    localparam int ZW        = 30;   // angle accumulator, 2^-24 rad units
    localparam int MAX_STEPS = 24;
    localparam int GUARD     = 14;
    localparam int PI_Q13    = 25736;
    localparam logic [ZW-1:0] HALF_PI_Z  = ZW'(26353589);
    localparam logic [31:0]   LEN_FACTOR = 32'd2670726652;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 y0_zero;
        logic                 x0_neg;
        logic                 origin;
    } stick_t;

    typedef struct packed {
        stick_t     right;
        stick_t     left;
        logic [7:0] right_trigger;
        logic [7:0] left_trigger;
    } item_t;

    typedef struct packed {
        logic signed [15:0] angle;
        logic [63:0]        prod;
        logic               origin;
    } polar_t;

    function automatic logic signed [ZW-1:0] atan_entry(input int unsigned i);
        logic signed [ZW-1:0] r;
        unique case (i)
            0:  r = ZW'(13176795);
            1:  r = ZW'(7778716);
            2:  r = ZW'(4110060);
            3:  r = ZW'(2086331);
            4:  r = ZW'(1047214);
            5:  r = ZW'(524117);
            6:  r = ZW'(262123);
            7:  r = ZW'(131069);
            8:  r = ZW'(65536);
            9:  r = ZW'(32768);
            10: r = ZW'(16384);
            11: r = ZW'(8192);
            12: r = ZW'(4096);
            13: r = ZW'(2048);
            14: r = ZW'(1024);
            15: r = ZW'(512);
            16: r = ZW'(256);
            17: r = ZW'(128);
            18: r = ZW'(64);
            19: r = ZW'(32);
            20: r = ZW'(16);
            21: r = ZW'(8);
            22: r = ZW'(4);
            23: r = ZW'(2);
            default: r = '0;
        endcase
        return r;
    endfunction

    // One vectoring iteration with a constant shift
    function automatic stick_t cordic_step(input stick_t s, input int unsigned i);
        stick_t r;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        r  = s;
        dx = s.y >>> i;
        dy = s.x >>> i;
        if (s.y > 0)
        begin
            r.x = s.x + dx;
            r.y = s.y - dy;
            r.z = s.z + atan_entry(i);
        end
        else
        begin
            r.x = s.x - dx;
            r.y = s.y + dy;
            r.z = s.z - atan_entry(i);
        end
        return r;
    endfunction

endpackage

### sv/stc_if.sv
// ----------------------------------------------------------------------------
// stc_in_if / stc_out_if: valid-ready channels of the stick converter
// One transaction moves at an edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface stc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic [7:0]         right_trigger;
    logic [7:0]         left_trigger;

    modport source (output valid, right_x, right_y, left_x, left_y,
                    right_trigger, left_trigger, input ready);
    modport sink   (input valid, right_x, right_y, left_x, left_y,
                    right_trigger, left_trigger, output ready);
endinterface

interface stc_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        right_length;
    logic signed [15:0] right_angle;
    logic [15:0]        left_length;
    logic signed [15:0] left_angle;
    logic [7:0]         right_trigger_out;
    logic [7:0]         left_trigger_out;

    modport source (output valid, right_length, right_angle, left_length,
                    left_angle, right_trigger_out, left_trigger_out,
                    input ready);
    modport sink   (input valid, right_length, right_angle, left_length,
                    left_angle, right_trigger_out, left_trigger_out,
                    output ready);
endinterface

### sv/stick_cartesian_to_polar.sv
// ----------------------------------------------------------------------------
// stick_cartesian_to_polar: thumbstick cartesian to polar converter
// An accepted transaction passes the queue, min(CORDIC_STEPS, 24) CORDIC stages,
// the multiply register and the rounding output register before it shows valid.
// Throughput: one transaction per cycle unless result.ready stalls the pipe.
// Reset: asynchronous, active low; clears queue and stage valids, no results.
// ----------------------------------------------------------------------------
module stick_cartesian_to_polar #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    stc_in_if.sink    sample,
    stc_out_if.source result
);

    // Front: scale each stick by 2^14, rotate a left-half vector by a
    // quarter turn so the CORDIC sees x >= 0, and note the axis cases.
    stc_pkg::item_t item;
    stc_pkg::item_t qdata;
    logic           push;
    logic           full;
    logic           empty;
    logic           pop;

    stc_front u_front (
        .sample (sample),
        .full   (full),
        .push   (push),
        .item   (item)
    );

    // Queue: hold up to two classified transactions so input acceptance
    // does not wait on the pipeline stall signal of the same cycle.
    stc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (item),
        .full  (full),
        .pop   (pop),
        .empty (empty),
        .rdata (qdata)
    );

    // Back: one vectoring iteration per stage, then the 1/(K*1000)
    // scaling multiply, rounding, clamping and the output register.
    stc_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .qdata  (qdata),
        .pop    (pop),
        .result (result)
    );

endmodule

### sv/stc_front.sv
// ----------------------------------------------------------------------------
// stc_front: input classification
// Scale each stick, pre-rotate a left-half vector by a quarter turn and
// flag the axis and origin cases.
// ----------------------------------------------------------------------------
module stc_front (
    stc_in_if.sink         sample,
    input  logic           full,
    output logic           push,
    output stc_pkg::item_t item
);

    function automatic stc_pkg::stick_t classify(input logic signed [15:0] x0,
                                                  input logic signed [15:0] y0);
        stc_pkg::stick_t s;
        logic signed [stc_pkg::XW-1:0] xs;
        logic signed [stc_pkg::XW-1:0] ys;
        xs = stc_pkg::XW'(x0) <<< stc_pkg::GUARD;
        ys = stc_pkg::XW'(y0) <<< stc_pkg::GUARD;
        s.x = xs;
        s.y = ys;
        s.z = '0;
        if (x0 < 0)
        begin
            if (y0 >= 0)
            begin
                s.x = ys;
                s.y = -xs;
                s.z = stc_pkg::HALF_PI_Z;
            end
            else
            begin
                s.x = -ys;
                s.y = xs;
                s.z = -stc_pkg::HALF_PI_Z;
            end
        end
        s.y0_zero = (y0 == 0);
        s.x0_neg  = (x0 < 0);
        s.origin  = (x0 == 0) && (y0 == 0);
        return s;
    endfunction

    assign sample.ready = !full;
    assign push         = sample.valid && !full;

    always_comb
    begin
        item.right         = classify(sample.right_x, sample.right_y);
        item.left          = classify(sample.left_x, sample.left_y);
        item.right_trigger = sample.right_trigger;
        item.left_trigger  = sample.left_trigger;
    end

endmodule

### sv/stc_queue.sv
// ----------------------------------------------------------------------------
// stc_queue: two-entry queue between front and back
// Decouple the input handshake from stalls of the CORDIC pipeline.
// ----------------------------------------------------------------------------
module stc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  stc_pkg::item_t wdata,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output stc_pkg::item_t rdata
);

    stc_pkg::item_t mem_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           do_pop;

    assign full   = (count_reg == 2'd2);
    assign empty  = (count_reg == 2'd0);
    assign rdata  = mem_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### sv/stc_back.sv
// ----------------------------------------------------------------------------
// stc_back: CORDIC vectoring pipeline and output register
// One iteration per stage, then the length multiply, then rounding,
// saturation and the output register. The whole pipe advances together.
// ----------------------------------------------------------------------------
module stc_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  stc_pkg::item_t qdata,
    output logic           pop,
    stc_out_if.source      result
);

    localparam int NS = (CORDIC_STEPS > stc_pkg::MAX_STEPS) ?
                        stc_pkg::MAX_STEPS : CORDIC_STEPS;

    stc_pkg::item_t  st_reg [NS+1];
    logic [NS:0]     vld_reg;
    stc_pkg::polar_t pr_reg, pl_reg;
    logic [7:0]      rt_reg, lt_reg;
    logic            mvld_reg;
    logic            ovld_reg;
    logic            advance;

    function automatic stc_pkg::polar_t finish(input stc_pkg::stick_t s);
        stc_pkg::polar_t p;
        logic signed [stc_pkg::ZW-1:0] zr;
        logic [31:0] xc;
        zr = (s.z + stc_pkg::ZW'(1024)) >>> 11;
        if (zr > stc_pkg::ZW'(stc_pkg::PI_Q13))
            p.angle = 16'(stc_pkg::PI_Q13);
        else if (zr < -stc_pkg::ZW'(stc_pkg::PI_Q13))
            p.angle = -16'(stc_pkg::PI_Q13);
        else
            p.angle = zr[15:0];
        if (s.y0_zero)
            p.angle = s.x0_neg ? 16'(stc_pkg::PI_Q13) : 16'd0;
        xc       = (s.x < 0) ? 32'd0 : s.x[31:0];
        p.prod   = 64'(xc) * 64'(stc_pkg::LEN_FACTOR);
        p.origin = s.origin;
        return p;
    endfunction

    function automatic logic [15:0] length_of(input stc_pkg::polar_t p);
        logic [63:0] l;
        l = (p.prod + (64'd1 << 45)) >> 46;
        if (p.origin)
            return 16'd0;
        if (l > 64'd65535)
            return 16'hFFFF;
        return l[15:0];
    endfunction

    // Advance whenever the output slot is free or being drained
    assign advance = !ovld_reg || result.ready;
    assign pop     = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            mvld_reg <= 1'b0;
            ovld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg  <= {vld_reg[NS-1:0], !empty};
            mvld_reg <= vld_reg[NS];
            ovld_reg <= mvld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st_reg[0] <= qdata;
        end
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                st_reg[k+1].right         <= stc_pkg::cordic_step(st_reg[k].right, k);
                st_reg[k+1].left          <= stc_pkg::cordic_step(st_reg[k].left, k);
                st_reg[k+1].right_trigger <= st_reg[k].right_trigger;
                st_reg[k+1].left_trigger  <= st_reg[k].left_trigger;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pr_reg <= finish(st_reg[NS].right);
            pl_reg <= finish(st_reg[NS].left);
            rt_reg <= st_reg[NS].right_trigger;
            lt_reg <= st_reg[NS].left_trigger;
            result.right_length      <= length_of(pr_reg);
            result.left_length       <= length_of(pl_reg);
            result.right_angle       <= pr_reg.angle;
            result.left_angle        <= pl_reg.angle;
            result.right_trigger_out <= rt_reg;
            result.left_trigger_out  <= lt_reg;
        end
    end

    assign result.valid = ovld_reg;

endmodule

### sv/stc_checker.sv
// ----------------------------------------------------------------------------
// stc_checker: port-level checks of the stick converter
// Watch the output channel for stall behaviour and value ranges.
// ----------------------------------------------------------------------------
module stc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] right_angle,
    input logic signed [15:0] left_angle,
    input logic [15:0]        right_length
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(right_length) && $stable(right_angle))
        else $error("result changed while stalled");

    a_right_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> right_angle <= 16'sd25736 && right_angle >= -16'sd25736)
        else $error("right angle out of range");

    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> left_angle <= 16'sd25736 && left_angle >= -16'sd25736)
        else $error("left angle out of range");

endmodule

bind stick_cartesian_to_polar stc_checker u_stc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .right_angle  (result.right_angle),
    .left_angle   (result.left_angle),
    .right_length (result.right_length)
);

### verif/stick_cartesian_to_polar_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stick_cartesian_to_polar_test: self-checking bench for the stick converter
// Drives stick samples through the valid-ready input channel and compares
// every result against a bit-exact CORDIC vectoring predictor.
// ----------------------------------------------------------------------------
module stick_cartesian_to_polar_test;

    localparam int STEPS = 16;

    typedef struct packed {
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic [7:0]         right_trigger;
        logic [7:0]         left_trigger;
    } sample_t;

    typedef struct packed {
        logic [15:0]        right_length;
        logic signed [15:0] right_angle;
        logic [15:0]        left_length;
        logic signed [15:0] left_angle;
        logic [7:0]         right_trigger_out;
        logic [7:0]         left_trigger_out;
    } polar_out_t;

    logic clk;
    logic rst_n;

    stc_in_if  sample ();
    stc_out_if result ();

    stick_cartesian_to_polar #(.CORDIC_STEPS(STEPS)) dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample.sink),
        .result (result.source)
    );

    polar_out_t expected_polar[$];
    int         error_count;
    bit         send_idle_on;   // random gaps on the sending side
    bit         recv_idle_on;   // random stalls on the receiving side

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Arctangent of 2^-i in units of 2^-24 rad
    function automatic longint atan_step(input int i);
        longint t[24];
        t = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
              131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
              256, 128, 64, 32, 16, 8, 4, 2};
        return t[i];
    endfunction

    // Angle (Q3.13) and length (/1000, 10 fraction bits) of one stick
    function automatic void stick_polar(input logic signed [15:0] sx,
                                        input logic signed [15:0] sy,
                                        output logic [15:0] len,
                                        output logic signed [15:0] ang);
        longint x;
        longint y;
        longint z;
        longint t;
        longint dx;
        longint dy;
        longint a;
        logic [127:0] prod;
        x = longint'(sx) * 16384;
        y = longint'(sy) * 16384;
        z = 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = 26353589;
            end
            else
            begin
                x = -y;
                y = t;
                z = -26353589;
            end
        end
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                z += atan_step(i);
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= atan_step(i);
            end
        end
        a = (z + 1024) >>> 11;
        if (a > 25736)
            a = 25736;
        if (a < -25736)
            a = -25736;
        if (sy == 0)
            a = (sx < 0) ? 25736 : 0;
        if (x < 0)
            x = 0;
        prod = (128'(x) * 128'(64'd2670726652) + (128'd1 << 45)) >> 46;
        if (prod > 65535)
            prod = 65535;
        if (sx == 0 && sy == 0)
            prod = 0;
        len = prod[15:0];
        ang = a[15:0];
    endfunction

    function automatic polar_out_t predict_polar(input sample_t s);
        polar_out_t p;
        stick_polar(s.right_x, s.right_y, p.right_length, p.right_angle);
        stick_polar(s.left_x, s.left_y, p.left_length, p.left_angle);
        p.right_trigger_out = s.right_trigger;
        p.left_trigger_out  = s.left_trigger;
        return p;
    endfunction

    // Send one transaction; when enabled, sometimes idle for a random burst first
    task automatic send_sample(input sample_t s);
        int gap;
        if (send_idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            sample.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample.valid         <= 1'b1;
        sample.right_x       <= s.right_x;
        sample.right_y       <= s.right_y;
        sample.left_x        <= s.left_x;
        sample.left_y        <= s.left_y;
        sample.right_trigger <= s.right_trigger;
        sample.left_trigger  <= s.left_trigger;
        do
            @(posedge clk);
        while (!sample.ready);
        // transaction accepted at this edge: queue its expectation
        expected_polar.push_back(predict_polar(s));
        @(negedge clk);
    endtask

    task automatic release_channel();
        sample.valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] axis_value();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'sh0001;
            4: return 16'shFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic sample_t random_sample(input bit edgy);
        sample_t s;
        s.right_x       = edgy ? axis_value() : 16'($urandom());
        s.right_y       = edgy ? axis_value() : 16'($urandom());
        s.left_x        = edgy ? axis_value() : 16'($urandom());
        s.left_y        = edgy ? axis_value() : 16'($urandom());
        s.right_trigger = 8'($urandom());
        s.left_trigger  = 8'($urandom());
        return s;
    endfunction

    // Hold until every expected result has come back
    task automatic drain();
        while (expected_polar.size() != 0)
            @(negedge clk);
    endtask

    // Origin, both axes, extreme corners and trigger extremes
    task automatic test_special_cases();
        logic signed [15:0] v[7];
        sample_t s;
        v = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd1, -16'sd1, 16'sd1000, -16'sd1000};
        for (int i = 0; i < 7; i++)
        begin
            s.right_x       = v[i];
            s.right_y       = '0;
            s.left_x        = '0;
            s.left_y        = v[i];
            s.right_trigger = (i % 2) ? 8'hFF : 8'h00;
            s.left_trigger  = (i % 2) ? 8'h00 : 8'hFF;
            send_sample(s);
        end
        for (int i = 0; i < 4; i++)
        begin
            s.right_x       = (i & 1) ? 16'sh7FFF : 16'sh8000;
            s.right_y       = (i & 2) ? 16'sh7FFF : 16'sh8000;
            s.left_x        = (i & 1) ? -16'sd1 : 16'sd1;
            s.left_y        = (i & 2) ? 16'sd1 : -16'sd1;
            s.right_trigger = 8'hA5;
            s.left_trigger  = 8'h5A;
            send_sample(s);
        end
        release_channel();
    endtask

    // Random content, half of it biased towards axis and extreme values
    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_sample(random_sample($urandom_range(0, 1)));
        release_channel();
    endtask

    // Result monitor: sample at the rising edge, compare with the oldest expectation
    always @(posedge clk)
    begin
        polar_out_t got;
        polar_out_t exp_p;
        if (rst_n && result.valid && result.ready)
        begin
            got = {result.right_length, result.right_angle, result.left_length,
                   result.left_angle, result.right_trigger_out,
                   result.left_trigger_out};
            if (expected_polar.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                error_count++;
            end
            else
            begin
                exp_p = expected_polar.pop_front();
                if (got !== exp_p)
                begin
                    $display("%0t: mismatch expected rl=%0d ra=%0d ll=%0d la=%0d rt=%0d lt=%0d",
                             $realtime, exp_p.right_length, exp_p.right_angle,
                             exp_p.left_length, exp_p.left_angle,
                             exp_p.right_trigger_out, exp_p.left_trigger_out);
                    $display("%0t:          actual   rl=%0d ra=%0d ll=%0d la=%0d rt=%0d lt=%0d",
                             $realtime, got.right_length, got.right_angle,
                             got.left_length, got.left_angle,
                             got.right_trigger_out, got.left_trigger_out);
                    error_count++;
                end
            end
        end
    end

    // Receiver back-pressure: random stall bursts while enabled
    initial
    begin
        int n;
        result.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (recv_idle_on && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 18);
                result.ready <= 1'b0;
                repeat (n) @(negedge clk);
                result.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        error_count          = 0;
        send_idle_on         = 1'b0;
        recv_idle_on         = 1'b0;
        rst_n                = 1'b0;
        sample.valid         = 1'b0;
        sample.right_x       = '0;
        sample.right_y       = '0;
        sample.left_x        = '0;
        sample.left_y        = '0;
        sample.right_trigger = '0;
        sample.left_trigger  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_special_cases();
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        test_random(400);
        // hold off the sender until the pipe has emptied completely
        drain();
        test_random(300);
        // final stretch at full rate on both sides
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        test_random(200);

        drain();
        repeat (STEPS + 10) @(negedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### stick_cartesian_to_polar.f
sv/stc_pkg.sv
sv/stc_if.sv
sv/stc_front.sv
sv/stc_queue.sv
sv/stc_back.sv
sv/stick_cartesian_to_polar.sv
sv/stc_checker.sv
verif/stick_cartesian_to_polar_test.sv
